// ----- hw/rtl/chbr_pkg.sv -----
// Shared types and constants for the call history back/redial block.
// No dependencies; imported by every module of the block except chbr_ram.
package chbr_pkg;

	localparam int DEPTH_DEF = 128;

	localparam int NUM_W      = 60;
	localparam int TIME_W     = 40;
	localparam int IDX_W      = 7;
	localparam int LOGCOUNT_W = 8;
	localparam int ENTRY_W    = NUM_W + TIME_W;

	localparam int S_TDATA_W = ((NUM_W + TIME_W + IDX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((NUM_W + TIME_W + LOGCOUNT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		CMD_CALL   = 2'd0,
		CMD_BACK   = 2'd1,
		CMD_REDIAL = 2'd2,
		CMD_HIST   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_PREV   = 2'd1,
		ST_NO_REDIAL = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic pop;
		logic emit;
	} dp_ctrl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic err;
	} dp_stat_t;

endpackage

// ----- hw/rtl/chbr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/chbr_ctrl.sv -----
// Sequencer for the call history block: accept, execute, pop (back and redial only), emit.
// Depends on chbr_pkg; drives the datapath through dp_ctrl_t.
module chbr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  chbr_pkg::dp_stat_t stat,
	output chbr_pkg::dp_ctrl_t ctrl
);
	import chbr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_POP  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   valid_q;
	logic   out_free;

	assign out_free  = !valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = valid_q;

	assign ctrl.load = s_tvalid && s_tready;
	assign ctrl.exec = (state_q == S_EXEC);
	assign ctrl.pop  = (state_q == S_POP);
	assign ctrl.emit = (state_q == S_EMIT) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				// back and redial need a second memory step
				if (!stat.err && (stat.cmd == CMD_BACK || stat.cmd == CMD_REDIAL))
					state_d = S_POP;
				else
					state_d = S_EMIT;
			end
			S_POP: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.emit)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/chbr_dp.sv -----
// Datapath: input latch, stack/log counters, three entry RAMs, result register.
// Depends on chbr_pkg and chbr_ram.
module chbr_dp #(
	parameter int DEPTH = chbr_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  chbr_pkg::dp_ctrl_t             ctrl,
	output chbr_pkg::dp_stat_t             stat,
	input  logic [1:0]                     in_cmd,
	input  logic [chbr_pkg::NUM_W-1:0]     in_number,
	input  logic [chbr_pkg::TIME_W-1:0]    in_time,
	input  logic [chbr_pkg::IDX_W-1:0]     in_index,
	output logic [1:0]                     out_status,
	output logic [chbr_pkg::NUM_W-1:0]     out_number,
	output logic [chbr_pkg::TIME_W-1:0]    out_time,
	output logic [chbr_pkg::LOGCOUNT_W-1:0] out_log_count
);
	import chbr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > IDX_W) ? CW : IDX_W;
	localparam int LW = (CW > LOGCOUNT_W) ? CW : LOGCOUNT_W;

	cmd_t              cmd_q;
	logic [NUM_W-1:0]  num_q;
	logic [TIME_W-1:0] time_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CW-1:0]     back_cnt_q, fwd_cnt_q, log_cnt_q;
	status_t           stat_q;

	logic              back_full, fwd_full, log_full;
	logic [IW-1:0]     idx_ext, log_ext;
	logic              err;
	status_t           err_code;
	logic [CW-1:0]     back_m1, back_m2, fwd_m1;
	logic [LW-1:0]     log_wide;

	logic               back_we, back_re, fwd_we, fwd_re, log_we, log_re;
	logic [AW-1:0]      back_raddr;
	logic [ENTRY_W-1:0] back_wdata, back_rdata, fwd_rdata, log_rdata, call_entry, sel_entry;

	assign back_full = (back_cnt_q == CW'(DEPTH));
	assign fwd_full  = (fwd_cnt_q == CW'(DEPTH));
	assign log_full  = (log_cnt_q == CW'(DEPTH));
	assign idx_ext   = IW'(idx_q);
	assign log_ext   = IW'(log_cnt_q);
	assign back_m1   = back_cnt_q - CW'(1);
	assign back_m2   = back_cnt_q - CW'(2);
	assign fwd_m1    = fwd_cnt_q - CW'(1);
	assign log_wide  = LW'(log_cnt_q);
	assign call_entry = {num_q, time_q};

	always_comb begin
		unique case (cmd_q)
			CMD_CALL: begin
				err      = 1'b0;
				err_code = ST_OK;
			end
			CMD_BACK: begin
				err      = (back_cnt_q < CW'(2));
				err_code = ST_NO_PREV;
			end
			CMD_REDIAL: begin
				err      = (fwd_cnt_q == '0);
				err_code = ST_NO_REDIAL;
			end
			CMD_HIST: begin
				err      = (idx_ext >= log_ext);
				err_code = ST_BAD_INDEX;
			end
			default: begin
				err      = 1'b0;
				err_code = ST_OK;
			end
		endcase
	end

	assign stat.cmd = cmd_q;
	assign stat.err = err;

	// back stack: call and redial push, back reads top then the entry below
	assign back_we    = (ctrl.exec && cmd_q == CMD_CALL && !back_full) ||
	                    (ctrl.pop && cmd_q == CMD_REDIAL && !back_full);
	assign back_wdata = ctrl.exec ? call_entry : fwd_rdata;
	assign back_re    = (ctrl.exec && cmd_q == CMD_BACK && !err) ||
	                    (ctrl.pop && cmd_q == CMD_BACK);
	assign back_raddr = ctrl.exec ? back_m1[AW-1:0] : back_m2[AW-1:0];

	assign fwd_we = ctrl.pop && cmd_q == CMD_BACK && !fwd_full;
	assign fwd_re = ctrl.exec && cmd_q == CMD_REDIAL && !err;

	assign log_we = ctrl.exec && cmd_q == CMD_CALL && !log_full;
	assign log_re = ctrl.exec && cmd_q == CMD_HIST && !err;

	chbr_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_back_ram (
		.clk   (clk),
		.we    (back_we),
		.waddr (back_cnt_q[AW-1:0]),
		.wdata (back_wdata),
		.re    (back_re),
		.raddr (back_raddr),
		.rdata (back_rdata)
	);

	chbr_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_fwd_ram (
		.clk   (clk),
		.we    (fwd_we),
		.waddr (fwd_cnt_q[AW-1:0]),
		.wdata (back_rdata),
		.re    (fwd_re),
		.raddr (fwd_m1[AW-1:0]),
		.rdata (fwd_rdata)
	);

	chbr_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_log_ram (
		.clk   (clk),
		.we    (log_we),
		.waddr (log_cnt_q[AW-1:0]),
		.wdata (call_entry),
		.re    (log_re),
		.raddr (idx_ext[AW-1:0]),
		.rdata (log_rdata)
	);

	always_comb begin
		if (stat_q != ST_OK) begin
			sel_entry = '0;
		end else begin
			unique case (cmd_q)
				CMD_CALL:   sel_entry = call_entry;
				CMD_BACK:   sel_entry = back_rdata;
				CMD_REDIAL: sel_entry = fwd_rdata;
				CMD_HIST:   sel_entry = log_rdata;
				default:    sel_entry = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q      <= CMD_CALL;
			stat_q     <= ST_OK;
			back_cnt_q <= '0;
			fwd_cnt_q  <= '0;
			log_cnt_q  <= '0;
		end else begin
			if (ctrl.load) cmd_q <= cmd_t'(in_cmd);
			if (ctrl.exec) begin
				stat_q <= err ? err_code : ST_OK;
				if (cmd_q == CMD_CALL) begin
					if (!back_full) back_cnt_q <= back_cnt_q + CW'(1);
					if (!log_full) log_cnt_q <= log_cnt_q + CW'(1);
					fwd_cnt_q <= '0;
				end
			end
			if (ctrl.pop) begin
				if (cmd_q == CMD_BACK) begin
					back_cnt_q <= back_m1;
					if (!fwd_full) fwd_cnt_q <= fwd_cnt_q + CW'(1);
				end else begin
					fwd_cnt_q <= fwd_m1;
					if (!back_full) back_cnt_q <= back_cnt_q + CW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			num_q  <= in_number;
			time_q <= in_time;
			idx_q  <= in_index;
		end
		if (ctrl.emit) begin
			out_status    <= stat_q;
			out_number    <= sel_entry[ENTRY_W-1:TIME_W];
			out_time      <= sel_entry[TIME_W-1:0];
			out_log_count <= log_wide[LOGCOUNT_W-1:0];
		end
	end

endmodule

// ----- hw/rtl/call_history_back_redial_top.sv -----
// Sequence: call, history read and error results pass through S_EXEC and S_EMIT before
// m_tvalid rises; successful back and redial also pass S_POP, which moves the entry between stacks.
// Throughput: one item at a time; the next beat is taken once the result is in
// the output register, and a stalled output holds the block in S_EMIT.
// Reset: arst_n clears the stack and log counts at once; RAM contents are not
// cleared and no clearing pass runs.
module call_history_back_redial_top #(
	parameter int DEPTH = chbr_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [1:0]                        s_tuser,  // cmd
	input  logic [chbr_pkg::S_TDATA_W-1:0]    s_tdata,  // phone_number, call_time, history_index, pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [1:0]                        m_tuser,  // status
	output logic [chbr_pkg::M_TDATA_W-1:0]    m_tdata   // result_number, result_time, log_count, pad
);
	import chbr_pkg::*;

	dp_ctrl_t               ctrl;
	dp_stat_t               stat;
	logic [NUM_W-1:0]       out_number;
	logic [TIME_W-1:0]      out_time;
	logic [LOGCOUNT_W-1:0]  out_log_count;

	chbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	chbr_dp #(.DEPTH(DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stat          (stat),
		.in_cmd        (s_tuser),
		.in_number     (s_tdata[NUM_W-1:0]),
		.in_time       (s_tdata[NUM_W+TIME_W-1:NUM_W]),
		.in_index      (s_tdata[NUM_W+TIME_W+IDX_W-1:NUM_W+TIME_W]),
		.out_status    (m_tuser),
		.out_number    (out_number),
		.out_time      (out_time),
		.out_log_count (out_log_count)
	);

	assign m_tdata = {{(M_TDATA_W - NUM_W - TIME_W - LOGCOUNT_W){1'b0}},
	                  out_log_count, out_time, out_number};

endmodule

// ----- hw/rtl/chbr_chk.sv -----
// Port-level checks for the call history block, bound to the top level.
// Depends on chbr_pkg.
module chbr_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [1:0]                     m_tuser,
	input logic [chbr_pkg::M_TDATA_W-1:0] m_tdata
);
	import chbr_pkg::*;

	// one item in flight: input closes right after a beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// error results carry a zero entry
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[NUM_W+TIME_W-1:0] == '0))
		else $error("error result with nonzero entry");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

endmodule

bind call_history_back_redial_top chbr_chk u_chbr_chk (.*);
